// ===== hw/rtl/kadr_pkg.sv =====
// Shared types, constants and lookup functions for the key autorepeat and
// direction resolver. No dependencies.
package kadr_pkg;

  localparam int KEY_BITS = 16;
  localparam int MASK_W = 16;
  localparam int DIR_W = 4;
  localparam int NUM_DIRS = 4;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_W = 3 * KEY_BITS + 2 * DIR_W;

  localparam int NUM_KEYS_DEF = 16;
  localparam int REPEAT_DELAY_DEF = 23;
  localparam int REPEAT_PERIOD_DEF = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DOWN_MASK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MASK = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MASK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_MASK = 8'd3;

  localparam logic [MASK_W-1:0] DOWN_MASK_RST = 16'd1;
  localparam logic [MASK_W-1:0] LEFT_MASK_RST = 16'd2;
  localparam logic [MASK_W-1:0] RIGHT_MASK_RST = 16'd4;
  localparam logic [MASK_W-1:0] UP_MASK_RST = 16'd8;

  localparam logic [DIR_W-1:0] DIR_NONE = 4'd0;

  localparam logic [NUM_DIRS-1:0] FLAGS_DOWN_UP = 4'b1001;
  localparam logic [NUM_DIRS-1:0] FLAGS_LEFT_RIGHT = 4'b0110;

  // index order: down, left, right, up
  localparam logic [1:0] PREF_ORDER [4][3] = '{
    '{2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd3, 2'd1},
    '{2'd1, 2'd2, 2'd0}
  };

  localparam logic [DIR_W-1:0] EIGHT_COMBO [4][4] = '{
    '{4'd2, 4'd1, 4'd3, 4'd0},
    '{4'd1, 4'd4, 4'd0, 4'd7},
    '{4'd3, 4'd0, 4'd6, 4'd9},
    '{4'd0, 4'd7, 4'd9, 4'd8}
  };

  typedef struct packed {
    logic [KEY_BITS-1:0] held;
    logic [KEY_BITS-1:0] trigger;
    logic [KEY_BITS-1:0] rpt;
  } key_flags_t;

  typedef struct packed {
    logic [DIR_W-1:0] four;
    logic [DIR_W-1:0] eight;
  } dir_t;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } pick_t;

  typedef logic [NUM_DIRS-1:0][MASK_W-1:0] mask_set_t;

  function automatic logic [DIR_W-1:0] dir_code(input logic [1:0] idx);
    dir_code = {1'b0, idx, 1'b0} + 4'd2;
  endfunction

  function automatic pick_t pref_pick(input logic [1:0] p, input logic [NUM_DIRS-1:0] flags);
    pick_t r;
    r.found = 1'b0;
    r.idx = 2'd0;
    for (int j = 0; j < 3; j++) begin
      if (!r.found && flags[PREF_ORDER[p][j]]) begin
        r.found = 1'b1;
        r.idx = PREF_ORDER[p][j];
      end
    end
    pref_pick = r;
  endfunction

endpackage

// ===== hw/rtl/kadr_repeat.sv =====
// Per-key held-tick counters, edge detect and autorepeat pulses.
// Depends on kadr_pkg.
module kadr_repeat
  import kadr_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF,
  parameter int REPEAT_DELAY = REPEAT_DELAY_DEF,
  parameter int REPEAT_PERIOD = REPEAT_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [KEY_BITS-1:0] held,
  output key_flags_t          flags
);

  localparam int LANES = (NUM_KEYS < KEY_BITS) ? NUM_KEYS : KEY_BITS;
  localparam int CNT_MAX = REPEAT_DELAY + REPEAT_PERIOD - 1;
  localparam int CNT_W = $clog2(CNT_MAX + 1);

  logic [KEY_BITS-1:0] prior_held;
  logic [CNT_W-1:0]    hold_count [LANES];
  logic [CNT_W-1:0]    hold_count_next [LANES];
  logic [KEY_BITS-1:0] rpt;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    always_comb begin
      if (!held[k]) begin
        hold_count_next[k] = '0;
      end else if (hold_count[k] >= CNT_W'(CNT_MAX)) begin
        hold_count_next[k] = CNT_W'(REPEAT_DELAY);
      end else begin
        hold_count_next[k] = hold_count[k] + 1'b1;
      end
      rpt[k] = held[k] && (hold_count_next[k] == CNT_W'(1) ||
                           hold_count_next[k] == CNT_W'(REPEAT_DELAY));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        hold_count[k] <= '0;
      end else if (advance) begin
        hold_count[k] <= hold_count_next[k];
      end
    end
  end

  for (genvar k = LANES; k < KEY_BITS; k++) begin : g_idle
    assign rpt[k] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_held <= '0;
    end else if (advance) begin
      prior_held <= held;
    end
  end

  assign flags.held = held;
  assign flags.trigger = held & ~prior_held;
  assign flags.rpt = rpt;

endmodule

// ===== hw/rtl/kadr_dir.sv =====
// Four-way and eight-way numpad direction from the held keys and the
// direction masks; keeps the latched four-way direction. Depends on kadr_pkg.
module kadr_dir
  import kadr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [KEY_BITS-1:0] held,
  input  mask_set_t           masks,
  output dir_t                dir
);

  logic [DIR_W-1:0]    last_dir;
  logic [DIR_W-1:0]    last_dir_next;
  logic [NUM_DIRS-1:0] on;
  logic                first_found;
  logic [1:0]          first_idx;
  logic [1:0]          last_idx;
  pick_t               keep_pick;
  pick_t               eight_pick;
  logic                opposite_only;

  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      on[i] = |(held & masks[i]);
    end
    first_found = 1'b0;
    first_idx = 2'd0;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (on[i]) begin
        first_found = 1'b1;
        first_idx = 2'(i);
      end
    end
    last_idx = last_dir[2:1] - 2'd1;
    keep_pick = pref_pick(last_idx, on);
    eight_pick = pref_pick(first_idx, on);
    opposite_only = (on == FLAGS_DOWN_UP) || (on == FLAGS_LEFT_RIGHT);

    last_dir_next = last_dir;
    if (opposite_only) begin
      dir.four = DIR_NONE;
    end else if (last_dir != DIR_NONE && on[last_idx] && keep_pick.found) begin
      dir.four = dir_code(keep_pick.idx);
    end else begin
      dir.four = first_found ? dir_code(first_idx) : DIR_NONE;
      last_dir_next = dir.four;
    end

    if (!first_found) begin
      dir.eight = DIR_NONE;
    end else if (eight_pick.found) begin
      dir.eight = EIGHT_COMBO[first_idx][eight_pick.idx];
    end else begin
      dir.eight = dir_code(first_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_dir <= DIR_NONE;
    end else if (advance) begin
      last_dir <= last_dir_next;
    end
  end

endmodule

// ===== hw/rtl/key_autorepeat_direction_resolver_core.sv =====
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline that stalls only on output backpressure.
// Reset (rst, synchronous, active high) clears counters, prior keys, the
// latched direction and both stages; masks return to 1, 2, 4, 8.
// Depends on kadr_pkg, kadr_repeat and kadr_dir.
module key_autorepeat_direction_resolver_core
  import kadr_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF,
  parameter int REPEAT_DELAY = REPEAT_DELAY_DEF,
  parameter int REPEAT_PERIOD = REPEAT_PERIOD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [KEY_BITS-1:0]  s_axis_tdata,  // keys_down
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // held_bits, trigger_bits, repeat_bits, dir_four, dir_eight
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  localparam logic [KEY_BITS-1:0] KEY_SPAN =
    (NUM_KEYS >= KEY_BITS) ? '1 : KEY_BITS'((64'd1 << NUM_KEYS) - 64'd1);

  logic                s1_valid;
  logic [KEY_BITS-1:0] s1_keys;
  logic                advance;
  mask_set_t           masks;
  key_flags_t          key_flags;
  dir_t                dir;

  assign advance = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks[0] <= DOWN_MASK_RST;
      masks[1] <= LEFT_MASK_RST;
      masks[2] <= RIGHT_MASK_RST;
      masks[3] <= UP_MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DOWN_MASK:  masks[0] <= cfg_data;
        REG_LEFT_MASK:  masks[1] <= cfg_data;
        REG_RIGHT_MASK: masks[2] <= cfg_data;
        REG_UP_MASK:    masks[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_keys <= s_axis_tdata & KEY_SPAN;
    end
  end

  kadr_repeat #(
    .NUM_KEYS      (NUM_KEYS),
    .REPEAT_DELAY  (REPEAT_DELAY),
    .REPEAT_PERIOD (REPEAT_PERIOD)
  ) u_repeat (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .held    (s1_keys),
    .flags   (key_flags)
  );

  kadr_dir u_dir (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .held    (s1_keys),
    .masks   (masks),
    .dir     (dir)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {dir.eight, dir.four, key_flags.rpt, key_flags.trigger,
                       key_flags.held};
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_trigger_fires_repeat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tdata[2*KEY_BITS-1:KEY_BITS] & ~m_axis_tdata[3*KEY_BITS-1:2*KEY_BITS]) == '0))
    else $error("new key press without repeat pulse");

  a_pulses_only_when_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (((m_axis_tdata[2*KEY_BITS-1:KEY_BITS] | m_axis_tdata[3*KEY_BITS-1:2*KEY_BITS])
        & ~m_axis_tdata[KEY_BITS-1:0]) == '0))
    else $error("trigger or repeat on a released key");
`endif

endmodule

// ===== dv/key_autorepeat_direction_resolver_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking test of key_autorepeat_direction_resolver_core: directed key patterns, then
// phases of random held-key sequences under several mask settings, checked against a predictor.
// Depends on kadr_pkg and the core RTL.
module key_autorepeat_direction_resolver_core_test;
  import kadr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = 8'hFF;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 135;
  localparam int PLAN_ROWS = 23;

  typedef enum int {DIR_DN = 0, DIR_LF = 1, DIR_RT = 2, DIR_UP = 3} dir_idx_e;

  typedef struct packed {
    logic [DIR_W-1:0]    dir_eight;
    logic [DIR_W-1:0]    dir_four;
    logic [KEY_BITS-1:0] repeat_bits;
    logic [KEY_BITS-1:0] trigger_bits;
    logic [KEY_BITS-1:0] held_bits;
  } tick_result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] keys;
    bit                  typed;
    tick_result_t        want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [KEY_BITS-1:0]  s_axis_tdata = '0;    // keys_down
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // held_bits, trigger_bits, repeat_bits, dir_four, dir_eight
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0]    cfg_data = '0;

  key_autorepeat_direction_resolver_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // order: down, left, right, up
  int unsigned prefer [4][3] = '{'{1, 2, 3}, '{0, 3, 2}, '{0, 3, 1}, '{1, 2, 0}};
  logic [DIR_W-1:0] diag_code [4][4] = '{
    '{4'd2, 4'd1, 4'd3, 4'd0},
    '{4'd1, 4'd4, 4'd0, 4'd7},
    '{4'd3, 4'd0, 4'd6, 4'd9},
    '{4'd0, 4'd7, 4'd9, 4'd8}
  };

  logic [MASK_W-1:0]   dir_masks [4];
  logic [KEY_BITS-1:0] prev_keys;
  logic [4:0]          hold_ticks [KEY_BITS];
  logic [DIR_W-1:0]    latched_dir;

  tick_result_t pending_ticks [$];
  int           errors = 0;
  bit           calm = 1'b0;
  int           stall_left = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{16'h0000, 1'b1, {4'd0, 4'd0, 16'h0000, 16'h0000, 16'h0000}},
    '{16'hFFFF, 1'b1, {4'd1, 4'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
    '{16'h0000, 1'b1, {4'd0, 4'd0, 16'h0000, 16'h0000, 16'h0000}},
    '{16'h0009, 1'b1, {4'd0, 4'd0, 16'h0009, 16'h0009, 16'h0009}},
    '{16'h0006, 1'b1, {4'd0, 4'd0, 16'h0006, 16'h0006, 16'h0006}},
    '{16'h0001, 1'b0, '0},
    '{16'h0003, 1'b0, '0},
    '{16'h0002, 1'b0, '0},
    '{16'h0006, 1'b0, '0},
    '{16'h0004, 1'b0, '0},
    '{16'h000C, 1'b0, '0},
    '{16'h0008, 1'b0, '0},
    '{16'h000A, 1'b0, '0},
    '{16'h0005, 1'b0, '0},
    '{16'h000E, 1'b0, '0},
    '{16'h000D, 1'b0, '0},
    '{16'h000B, 1'b0, '0},
    '{16'h0007, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h0000, 1'b0, '0}
  };

  task automatic resolve_tick(input logic [KEY_BITS-1:0] keys, output tick_result_t r);
    logic [NUM_DIRS-1:0] on;
    int unsigned p;
    int unsigned o;
    bit done;
    r = '0;
    r.held_bits = keys;
    r.trigger_bits = keys & ~prev_keys;
    for (int k = 0; k < KEY_BITS; k++) begin
      if (keys[k]) begin
        if (hold_ticks[k] >= REPEAT_DELAY_DEF + REPEAT_PERIOD_DEF - 1) begin
          hold_ticks[k] = 5'(REPEAT_DELAY_DEF);
        end else begin
          hold_ticks[k] = hold_ticks[k] + 5'd1;
        end
        if (hold_ticks[k] == 5'd1 || hold_ticks[k] == 5'(REPEAT_DELAY_DEF)) begin
          r.repeat_bits[k] = 1'b1;
        end
      end else begin
        hold_ticks[k] = '0;
      end
    end
    prev_keys = keys;
    for (int i = 0; i < NUM_DIRS; i++) begin
      on[i] = (keys & dir_masks[i]) != '0;
    end

    done = 1'b0;
    if (on == FLAGS_DOWN_UP || on == FLAGS_LEFT_RIGHT) begin
      r.dir_four = DIR_NONE;
    end else begin
      if (latched_dir != DIR_NONE) begin
        p = ((latched_dir >> 1) - 1) & 3;
        if (on[p]) begin
          for (int j = 0; j < 3 && !done; j++) begin
            o = prefer[p][j];
            if (on[o]) begin
              r.dir_four = 4'((o + 1) * 2);
              done = 1'b1;
            end
          end
        end
      end
      if (!done) begin
        r.dir_four = DIR_NONE;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
          if (on[i]) r.dir_four = 4'((i + 1) * 2);
        end
        latched_dir = r.dir_four;
      end
    end

    done = 1'b0;
    for (int i = 0; i < NUM_DIRS && !done; i++) begin
      if (on[i]) begin
        done = 1'b1;
        r.dir_eight = 4'((i + 1) * 2);
        for (int j = 2; j >= 0; j--) begin
          o = prefer[i][j];
          if (on[o]) r.dir_eight = diag_code[i][o];
        end
      end
    end
  endtask

  task automatic write_mask_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_UP_MASK) dir_masks[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_keys(input logic [KEY_BITS-1:0] keys, input bit typed,
                           input tick_result_t want);
    tick_result_t r;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= keys;
    do @(posedge clk); while (!s_axis_tready);
    resolve_tick(keys, r);
    pending_ticks.insert(pending_ticks.size(), typed ? want : r);
  endtask

  task automatic drain_ticks();
    s_axis_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // output backpressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = tick_result_t'(m_axis_tdata);
      if (pending_ticks.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = pending_ticks.pop_front();
        if (got.held_bits !== exp_r.held_bits) begin
          $error("held_bits: expected %h, got %h", exp_r.held_bits, got.held_bits);
          errors++;
        end
        if (got.trigger_bits !== exp_r.trigger_bits) begin
          $error("trigger_bits: expected %h, got %h", exp_r.trigger_bits, got.trigger_bits);
          errors++;
        end
        if (got.repeat_bits !== exp_r.repeat_bits) begin
          $error("repeat_bits: expected %h, got %h", exp_r.repeat_bits, got.repeat_bits);
          errors++;
        end
        if (got.dir_four !== exp_r.dir_four) begin
          $error("dir_four: expected %0d, got %0d", exp_r.dir_four, got.dir_four);
          errors++;
        end
        if (got.dir_eight !== exp_r.dir_eight) begin
          $error("dir_eight: expected %0d, got %0d", exp_r.dir_eight, got.dir_eight);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [MASK_W-1:0]   masks [4];
    logic [KEY_BITS-1:0] keys;
    logic [KEY_BITS-1:0] flips;
    dir_masks = '{DOWN_MASK_RST, LEFT_MASK_RST, RIGHT_MASK_RST, UP_MASK_RST};
    prev_keys = '0;
    latched_dir = DIR_NONE;
    for (int k = 0; k < KEY_BITS; k++) hold_ticks[k] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < PLAN_ROWS; n++) begin
      send_keys(plan[n].keys, plan[n].typed, plan[n].want);
    end

    keys = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_ticks();
      case (ph)
        0: masks = '{DOWN_MASK_RST, LEFT_MASK_RST, RIGHT_MASK_RST, UP_MASK_RST};
        1: masks = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        2: masks = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        4: masks = '{16'h00FF, 16'h0FF0, 16'hFF00, 16'hF00F};
        5: masks = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        6: begin
          for (int i = 0; i < NUM_DIRS; i++) masks[i] = 16'($urandom & $urandom & $urandom);
        end
        default: begin
          for (int i = 0; i < NUM_DIRS; i++) masks[i] = 16'd1 << $urandom_range(0, 15);
        end
      endcase
      write_mask_reg(REG_DOWN_MASK, masks[DIR_DN]);
      write_mask_reg(REG_LEFT_MASK, masks[DIR_LF]);
      write_mask_reg(REG_RIGHT_MASK, masks[DIR_RT]);
      write_mask_reg(REG_UP_MASK, masks[DIR_UP]);
      if (ph % 2 == 1) write_mask_reg(REG_SPARE, 16'($urandom));
      if (ph == 3) write_mask_reg(REG_TOP, 16'hFFFF);
      calm = (ph == PHASES - 1);

      // mostly long holds with sparse presses and releases, some noise
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          keys = 16'($urandom);
        end else begin
          flips = '0;
          for (int k = 0; k < KEY_BITS; k++) flips[k] = ($urandom_range(0, 23) == 0);
          keys = keys ^ flips;
        end
        send_keys(keys, 1'b0, '0);
      end
    end

    drain_ticks();
    if (errors == 0 && pending_ticks.size() == 0) begin
      $display("key_autorepeat_direction_resolver_core test passed");
    end else begin
      $display("key_autorepeat_direction_resolver_core test failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("key_autorepeat_direction_resolver_core test failed");
    $finish;
  end

endmodule
